[rtl/tthc_pkg.sv]
// Package for the touch tap/hold classifier: codes, register map and shared types.
`default_nettype none

package tthc_pkg;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_POLL   = 1'b1
  } tthc_op_t;

  typedef enum logic [1:0] {
    REG_ON_HYST   = 2'd0,
    REG_OFF_HYST  = 2'd1,
    REG_HOLD_MS   = 2'd2,
    REG_UNUSED    = 2'd3
  } tthc_reg_t;

  localparam logic [15:0] ON_HYST_RESET  = 16'd50;
  localparam logic [15:0] OFF_HYST_RESET = 16'd50;
  localparam logic [15:0] HOLD_MS_RESET  = 16'd1000;

  typedef struct packed {
    logic [15:0] last_reading;
    logic        touched;
    logic        released;
    logic [31:0] touch_start_us;
  } tthc_state_t;

  typedef struct packed {
    logic tap;
    logic hold;
  } tthc_result_t;

  // ms -> us: v*1000 = v*1024 - v*16 - v*8
  function automatic logic [31:0] ms_to_us(input logic [15:0] ms);
    logic [31:0] v;
    v = {16'd0, ms};
    return (v << 10) - (v << 4) - (v << 3);
  endfunction

endpackage

`default_nettype wire

[rtl/tthc_eval.sv]
// Next-state and result logic for one sample or poll request.
`default_nettype none

module tthc_eval
  import tthc_pkg::*;
(
  input  tthc_state_t  state,
  input  tthc_op_t     op,
  input  logic [15:0]  sample_value,
  input  logic [31:0]  now_us,
  input  logic [15:0]  on_hyst,
  input  logic [15:0]  off_hyst,
  input  logic [31:0]  hold_limit_us,
  output tthc_state_t  state_nxt,
  output tthc_result_t result
);

  logic [16:0] drop_sum;
  logic [16:0] rise_sum;
  logic        is_touch;
  logic        is_release;
  logic [31:0] elapsed;
  logic        hold_hit;
  logic        touched_after_hold;

  // both sides are non-negative, so 17-bit unsigned sums cover the signed compare
  assign drop_sum   = {1'b0, sample_value} + {1'b0, on_hyst};
  assign rise_sum   = {1'b0, state.last_reading} + {1'b0, off_hyst};
  assign is_touch   = !state.touched && (drop_sum < {1'b0, state.last_reading});
  assign is_release = {1'b0, sample_value} > rise_sum;

  assign elapsed  = now_us - state.touch_start_us;
  assign hold_hit = state.touched && !state.released && (elapsed >= hold_limit_us);
  assign touched_after_hold = state.touched && !hold_hit;

  always_comb begin
    state_nxt   = state;
    result.tap  = 1'b0;
    result.hold = 1'b0;
    case (op)
      OP_SAMPLE: begin
        state_nxt.last_reading = sample_value;
        if (is_touch) begin
          state_nxt.touched        = 1'b1;
          state_nxt.touch_start_us = now_us;
        end else if (is_release) begin
          state_nxt.released = 1'b1;
        end
      end
      OP_POLL: begin
        result.hold = hold_hit;
        // a hold clears touched first, so the same poll cannot also tap
        result.tap  = touched_after_hold && state.released;
        state_nxt.touched  = touched_after_hold && !state.released;
        state_nxt.released = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/touch_tap_hold_classifier_core.sv]
// Top level of the touch tap/hold classifier: handshakes, registers, state and result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  in_      | request   | in_valid / in_stall  | in_operation, in_sample_value, in_now_us
//  out_     | result    | out_valid / out_stall| out_tap_event, out_hold_event
//  cfg      | APB write | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One request per cycle while in_stall is low; its result is in the output register the next cycle.
// The state update and the result come from one level of compare logic.
// The hold limit in us is computed when hold_time_ms is written.
// in_stall is high only while a result waits and out_stall is high.
// rst_n is synchronous: state, config registers and the output valid go to reset values; result_r is not reset.
`default_nettype none

module touch_tap_hold_classifier_core
  import tthc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_sample_value,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tap_event,
  output logic        out_hold_event,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]  on_hyst_r;
  logic [15:0]  off_hyst_r;
  logic [15:0]  hold_ms_r;
  logic [31:0]  hold_limit_r;
  tthc_state_t  state_r;
  tthc_state_t  state_nxt;
  tthc_result_t result;
  tthc_result_t result_r;
  logic         out_valid_r;
  logic         in_accept;
  logic         out_accept;
  logic         cfg_write;
  tthc_reg_t    cfg_reg;

  assign pready    = 1'b1;
  assign cfg_reg   = tthc_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_reg)
      REG_ON_HYST:  prdata = {16'd0, on_hyst_r};
      REG_OFF_HYST: prdata = {16'd0, off_hyst_r};
      REG_HOLD_MS:  prdata = {16'd0, hold_ms_r};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_hyst_r    <= ON_HYST_RESET;
      off_hyst_r   <= OFF_HYST_RESET;
      hold_ms_r    <= HOLD_MS_RESET;
      hold_limit_r <= ms_to_us(HOLD_MS_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_ON_HYST:  on_hyst_r  <= pwdata[15:0];
        REG_OFF_HYST: off_hyst_r <= pwdata[15:0];
        REG_HOLD_MS: begin
          hold_ms_r    <= pwdata[15:0];
          hold_limit_r <= ms_to_us(pwdata[15:0]);
        end
        default: ;
      endcase
    end
  end

  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  tthc_eval u_eval (
    .state         (state_r),
    .op            (tthc_op_t'(in_operation)),
    .sample_value  (in_sample_value),
    .now_us        (in_now_us),
    .on_hyst       (on_hyst_r),
    .off_hyst      (off_hyst_r),
    .hold_limit_us (hold_limit_r),
    .state_nxt     (state_nxt),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tap_event  = result_r.tap;
  assign out_hold_event = result_r.hold;

  a_no_tap_with_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(result_r.tap && result_r.hold))
    else $error("tap and hold reported together");

  a_sample_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_operation == OP_SAMPLE)) |=>
      (out_valid_r && !result_r.tap && !result_r.hold))
    else $error("sample request produced an event");

  a_limit_tracks_ms: assert property (@(posedge clk) disable iff (!rst_n)
    hold_limit_r == ms_to_us(hold_ms_r))
    else $error("hold limit out of step with hold_time_ms");

  a_poll_clears_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_operation == OP_POLL)) |=> !state_r.released)
    else $error("release flag survived a poll");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the touch tap/hold classifier core.
`timescale 1ns / 100ps

module testbench
  import tthc_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [15:0] in_sample_value;
  logic [31:0] in_now_us;
  logic        out_valid;
  logic        out_stall;
  logic        out_tap_event;
  logic        out_hold_event;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  touch_tap_hold_classifier_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_sample_value(in_sample_value),
    .in_now_us      (in_now_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tap_event  (out_tap_event),
    .out_hold_event (out_hold_event),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // classifier copy: registers and channel state
  logic [15:0] cf_on_hyst;
  logic [15:0] cf_off_hyst;
  logic [15:0] cf_hold_ms;
  logic [15:0] tr_last_reading;
  logic        tr_touched;
  logic        tr_released;
  logic [31:0] tr_touch_start;

  tthc_result_t pending_events[$];
  tthc_result_t got_event;
  tthc_result_t want_event;

  int          error_count;
  int          cycle_count;
  int          requests_sent;
  int          taps_seen;
  int          holds_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_hold_left;
  logic [31:0] clock_us;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_events.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic tthc_result_t classify_request(tthc_op_t op, logic [15:0] reading,
                                                    logic [31:0] now);
    tthc_result_t res;
    int           cur;
    int           prev;
    logic [31:0]  elapsed;
    logic [31:0]  limit_us;
    res = '0;
    if (op == OP_SAMPLE) begin
      cur  = {16'd0, reading};
      prev = {16'd0, tr_last_reading};
      if (!tr_touched && (cur + int'({16'd0, cf_on_hyst}) < prev)) begin
        tr_touched     = 1'b1;
        tr_touch_start = now;
      end else if (cur - int'({16'd0, cf_off_hyst}) > prev) begin
        tr_released = 1'b1;
      end
      tr_last_reading = reading;
    end else begin
      elapsed  = now - tr_touch_start;
      limit_us = {16'd0, cf_hold_ms} * 32'd1000;
      if (tr_touched && !tr_released && elapsed >= limit_us) begin
        res.hold   = 1'b1;
        tr_touched = 1'b0;
      end
      // a hold already cleared the touch, so no tap in the same poll
      if (tr_touched && tr_released) begin
        res.tap    = 1'b1;
        tr_touched = 1'b0;
      end
      tr_released = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // result side: check and random / forced stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_event.tap  = out_tap_event;
      got_event.hold = out_hold_event;
      if (pending_events.size() == 0) begin
        $display("%0t unexpected result: expected none, got tap=%0b hold=%0b",
                 $time, got_event.tap, got_event.hold);
        error_count++;
      end else begin
        want_event = pending_events.pop_front();
        if (got_event.tap !== want_event.tap) begin
          $display("%0t tap_event mismatch: expected %0b, got %0b",
                   $time, want_event.tap, got_event.tap);
          error_count++;
        end
        if (got_event.hold !== want_event.hold) begin
          $display("%0t hold_event mismatch: expected %0b, got %0b",
                   $time, want_event.hold, got_event.hold);
          error_count++;
        end
        taps_seen  += int'(want_event.tap);
        holds_seen += int'(want_event.hold);
      end
    end
    if (stall_hold_left > 0) begin
      out_stall <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  task automatic send_item(tthc_op_t op, logic [15:0] reading, logic [31:0] now);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_sample_value <= reading;
    in_now_us       <= now;
    do @(posedge clk); while (in_stall);
    pending_events.push_back(classify_request(op, reading, now));
    requests_sent++;
  endtask

  // drop valid, let every result drain, then allow the pipe to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(tthc_reg_t idx, logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ON_HYST:  cf_on_hyst  = value;
      REG_OFF_HYST: cf_off_hyst = value;
      REG_HOLD_MS:  cf_hold_ms  = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // threshold edges, hold timing, wrap of the time counter, tap vs hold
  task automatic test_directed();
    logic [31:0] t;
    t = 32'h1000_0000;
    send_item(OP_SAMPLE, 16'd0, t);
    send_item(OP_POLL, 16'($urandom), t);
    send_item(OP_SAMPLE, 16'd1000, t);       // release without touch
    send_item(OP_POLL, 16'($urandom), t);
    send_item(OP_SAMPLE, 16'd950, t);        // drop equal to hysteresis
    t += 32'd10;
    send_item(OP_SAMPLE, 16'd899, t);        // drop one past it
    send_item(OP_POLL, 16'($urandom), t + 32'd999_999);
    send_item(OP_POLL, 16'($urandom), t + 32'd1_000_000);
    send_item(OP_POLL, 16'($urandom), t + 32'd1_000_001);
    send_item(OP_SAMPLE, 16'd949, t);        // rise equal to hysteresis
    send_item(OP_SAMPLE, 16'd1000, t);
    t += 32'd77;
    send_item(OP_SAMPLE, 16'd900, t);
    send_item(OP_SAMPLE, 16'd1100, t);
    send_item(OP_POLL, 16'($urandom), t + 32'd2_000_000); // tap wins over an elapsed hold
    send_item(OP_SAMPLE, 16'hFFFF, t);
    t = 32'hFFFF_FF00;
    send_item(OP_SAMPLE, 16'd0, t);
    send_item(OP_POLL, 16'($urandom), t + 32'd999_999);   // wraps past zero
    send_item(OP_POLL, 16'($urandom), t + 32'd1_000_000);
    send_item(OP_SAMPLE, 16'hFFFF, t);
    send_item(OP_POLL, 16'($urandom), t);
    send_item(OP_SAMPLE, 16'd0, t);
    send_item(OP_SAMPLE, 16'd30, t);
    send_item(OP_POLL, 16'($urandom), t - 32'd1);
    send_item(OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_POLL, 16'hFFFF, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [31:0] t;
    t = $urandom;
    cfg_write(REG_ON_HYST, 16'd0);
    cfg_write(REG_OFF_HYST, 16'd0);
    cfg_write(REG_HOLD_MS, 16'd0);
    send_item(OP_SAMPLE, 16'd100, t);
    send_item(OP_SAMPLE, 16'd99, t);
    send_item(OP_POLL, 16'($urandom), t);    // zero limit fires at once
    send_item(OP_SAMPLE, 16'd100, t);
    send_item(OP_SAMPLE, 16'd100, t);
    send_item(OP_POLL, 16'($urandom), t);
    wait_idle();
    cfg_write(REG_ON_HYST, 16'hFFFF);
    cfg_write(REG_OFF_HYST, 16'hFFFF);
    cfg_write(REG_HOLD_MS, 16'hFFFF);
    send_item(OP_SAMPLE, 16'hFFFF, t);
    send_item(OP_SAMPLE, 16'd0, t);
    send_item(OP_SAMPLE, 16'hFFFF, t);
    send_item(OP_POLL, 16'($urandom), t);
    wait_idle();
    cfg_write(REG_ON_HYST, 16'd100);
    cfg_write(REG_UNUSED, 16'($urandom));    // must change nothing
    send_item(OP_SAMPLE, 16'hFFFF, t);
    send_item(OP_SAMPLE, 16'd0, t);
    send_item(OP_POLL, 16'($urandom), t + 32'd65_534_999);
    send_item(OP_POLL, 16'($urandom), t + 32'd65_535_000);
    wait_idle();
  endtask

  // touch / hold / release sequences with random content, plus some noise
  task automatic test_gestures(int count);
    int          stop_at;
    int          base;
    int          low;
    int          steps;
    int          limit_us;
    stop_at  = requests_sent + count;
    limit_us = int'(cf_hold_ms) * 1000;
    while (requests_sent < stop_at) begin
      if ($urandom_range(9, 0) < 2) begin
        send_item(tthc_op_t'($urandom_range(1, 0)), 16'($urandom), $urandom);
      end else begin
        base = $urandom_range(60000, 4000);
        clock_us += $urandom_range(3000, 0);
        send_item(OP_SAMPLE, clamp16(base + $urandom_range(20, 0) - 10), clock_us);
        low = base - int'(cf_on_hyst) - $urandom_range(300, 0);
        clock_us += $urandom_range(500, 0);
        send_item(OP_SAMPLE, clamp16(low), clock_us);
        steps = $urandom_range(4, 0);
        repeat (steps) begin
          if ($urandom_range(1, 0) == 1) begin
            clock_us += $urandom_range(2 * limit_us + 10, 0);
            send_item(OP_POLL, 16'($urandom), clock_us);
          end else begin
            clock_us += $urandom_range(200, 0);
            send_item(OP_SAMPLE, clamp16(low + $urandom_range(40, 0) - 20), clock_us);
          end
        end
        if ($urandom_range(3, 0) != 0) begin
          clock_us += $urandom_range(500, 0);
          send_item(OP_SAMPLE,
                    clamp16(low + int'(cf_off_hyst) + $urandom_range(300, 0) - 20),
                    clock_us);
        end
        clock_us += $urandom_range(limit_us + 10, 0);
        send_item(OP_POLL, 16'($urandom), clock_us);
      end
    end
    wait_idle();
  endtask

  // receiver holds off long enough for the core to fill and stall its input
  task automatic test_backpressure();
    int saved_send;
    int saved_recv;
    saved_send    = send_idle_pct;
    saved_recv    = recv_idle_pct;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_hold_left = 300;
    repeat (40) begin
      clock_us += $urandom_range(4000, 0);
      send_item(tthc_op_t'($urandom_range(1, 0)), 16'($urandom), clock_us);
    end
    wait_idle();
    send_idle_pct = saved_send;
    recv_idle_pct = saved_recv;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OP_SAMPLE;
    in_sample_value <= '0;
    in_now_us       <= '0;
    out_stall       <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    error_count     = 0;
    cycle_count     = 0;
    requests_sent   = 0;
    taps_seen       = 0;
    holds_seen      = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    stall_hold_left = 0;
    clock_us        = $urandom;
    cf_on_hyst      = ON_HYST_RESET;
    cf_off_hyst     = OFF_HYST_RESET;
    cf_hold_ms      = HOLD_MS_RESET;
    tr_last_reading = '0;
    tr_touched      = 1'b0;
    tr_released     = 1'b0;
    tr_touch_start  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 46;
    test_directed();
    test_register_extremes();
    cfg_write(REG_ON_HYST, ON_HYST_RESET);
    cfg_write(REG_OFF_HYST, OFF_HYST_RESET);
    cfg_write(REG_HOLD_MS, 16'd1);
    test_gestures(370);

    send_idle_pct = 46;
    recv_idle_pct = 37;
    cfg_write(REG_ON_HYST, 16'($urandom_range(300, 0)));
    cfg_write(REG_OFF_HYST, 16'($urandom_range(300, 0)));
    cfg_write(REG_HOLD_MS, 16'($urandom_range(3, 0)));
    test_backpressure();
    test_gestures(370);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_ON_HYST, 16'($urandom_range(1000, 0)));
    cfg_write(REG_OFF_HYST, 16'($urandom_range(1000, 0)));
    cfg_write(REG_HOLD_MS, 16'd2);
    test_gestures(370);

    wait_idle();
    $display("covered %0d requests over several register settings and stall patterns",
             requests_sent);
    $display("expected events seen: %0d taps, %0d holds; %0d errors",
             taps_seen, holds_seen, error_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[touch_tap_hold_classifier_core.f]
rtl/tthc_pkg.sv
rtl/tthc_eval.sv
rtl/touch_tap_hold_classifier_core.sv
sim/testbench.sv
